/* rtl/core/packet_header_classifier_stats_macros.svh */
// ----------------------------------------------------------------------------
// packet header classifier stats: assertion macros
// shared concurrent check macros, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef PACKET_HEADER_CLASSIFIER_STATS_MACROS_SVH
`define PACKET_HEADER_CLASSIFIER_STATS_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PHCS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("phcs check failed");
// next-cycle implication
`define PHCS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("phcs check failed");
`else
`define PHCS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PHCS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/phcs_pkg.sv */
// ----------------------------------------------------------------------------
// phcs_pkg
// types and constants of the packet header classifier and its statistics
// ----------------------------------------------------------------------------
package phcs_pkg;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 192;
	localparam int CAP_LEN_W  = 16;
	localparam int EVENT_N    = 13;
	localparam int EVENT_IDX_W = 4;

	// ethertypes
	localparam logic [15:0] ETYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

	// ip protocols
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	// tcp flag bits
	localparam logic [8:0] FLAG_MASK = 9'h1FF;
	localparam logic [8:0] FLAG_FIN  = 9'h001;
	localparam logic [8:0] FLAG_SYN  = 9'h002;
	localparam logic [8:0] FLAG_RST  = 9'h004;
	localparam logic [8:0] FLAG_PSH  = 9'h008;
	localparam logic [8:0] FLAG_ACK  = 9'h010;
	localparam logic [8:0] FLAG_URG  = 9'h020;

	// frame classes
	localparam logic [3:0] CLS_SHORT     = 4'd0;
	localparam logic [3:0] CLS_ARP       = 4'd1;
	localparam logic [3:0] CLS_IPV6      = 4'd2;
	localparam logic [3:0] CLS_OTHER_ET  = 4'd3;
	localparam logic [3:0] CLS_IPV4_BAD  = 4'd4;
	localparam logic [3:0] CLS_ICMP      = 4'd5;
	localparam logic [3:0] CLS_TCP       = 4'd6;
	localparam logic [3:0] CLS_UDP       = 4'd7;
	localparam logic [3:0] CLS_OTHER_PR  = 4'd8;

	// event counter indexes
	localparam int EV_ARP     = 0;
	localparam int EV_IPV4    = 1;
	localparam int EV_IPV6    = 2;
	localparam int EV_TCP     = 3;
	localparam int EV_UDP     = 4;
	localparam int EV_ICMP    = 5;
	localparam int EV_UNKNOWN = 6;
	localparam int EV_SYN     = 7;
	localparam int EV_ACK     = 8;
	localparam int EV_FIN     = 9;
	localparam int EV_RST     = 10;
	localparam int EV_PSH     = 11;
	localparam int EV_URG     = 12;

	// counter selects
	localparam logic [4:0] SEL_PACKETS    = 5'd0;
	localparam logic [4:0] SEL_CAP_BYTES  = 5'd1;
	localparam logic [4:0] SEL_ORIG_BYTES = 5'd2;
	localparam logic [4:0] SEL_SMALLEST   = 5'd3;
	localparam logic [4:0] SEL_LARGEST    = 5'd4;
	localparam logic [4:0] SEL_EVENT_BASE = 5'd5;
	localparam logic [4:0] SEL_EVENT_END  = 5'd18;

	// header offsets in the frame (OFS_FLAGS within the tcp header), header lengths and ip header constants
	localparam logic [6:0] OFS_ETYPE_HI = 7'd12;
	localparam logic [6:0] OFS_ETYPE_LO = 7'd13;
	localparam logic [6:0] OFS_VIHL     = 7'd14;
	localparam logic [6:0] OFS_PROTO    = 7'd23;
	localparam logic [6:0] OFS_SRC      = 7'd26;
	localparam logic [6:0] OFS_DST      = 7'd30;
	localparam logic [6:0] OFS_IP_END   = 7'd34;
	localparam logic [6:0] OFS_FLAGS    = 7'd12;
	localparam logic [6:0] TCP_HDR_LEN  = 7'd20;
	localparam logic [6:0] UDP_HDR_LEN  = 7'd8;
	localparam logic [3:0] IHL_MIN      = 4'd5;
	localparam logic [3:0] IP_VERSION4  = 4'd4;

	typedef struct packed {
		logic [15:0] etype;
		logic [7:0]  vihl;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] ports;
		logic [8:0]  flags;
	} frame_t;

	typedef struct packed {
		logic [3:0]         cls;
		logic [31:0]        src;
		logic [31:0]        dst;
		logic [15:0]        sport;
		logic [15:0]        dport;
		logic               pv;
		logic [8:0]         flags;
		logic [EVENT_N-1:0] events;
	} summ_t;

	function automatic logic [6:0] transport_start(input logic [3:0] ihl);
		return OFS_VIHL + {1'b0, ihl, 2'b00};
	endfunction

endpackage

/* rtl/core/phcs_parser.sv */
// ----------------------------------------------------------------------------
// phcs_parser
// byte position counter and header field capture of the frame in progress
// ----------------------------------------------------------------------------
module phcs_parser #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic                   last,
	input  logic [7:0]             data_byte,
	output phcs_pkg::frame_t       hdr_nxt,
	output logic [LENGTH_BITS-1:0] len_nxt
);
	import phcs_pkg::*;

	frame_t                 hdr_q;
	logic [LENGTH_BITS-1:0] pos_q;
	logic [3:0]             ihl;
	logic [LENGTH_BITS-1:0] tl;

	assign ihl = hdr_q.vihl[3:0];
	assign tl  = LENGTH_BITS'(transport_start(ihl));

	assign len_nxt = (pos_q != '1) ? pos_q + LENGTH_BITS'(1) : pos_q;

	always_comb begin
		hdr_nxt = hdr_q;
		if (pos_q == LENGTH_BITS'(OFS_ETYPE_HI)) begin
			hdr_nxt.etype[15:8] = data_byte;
		end else if (pos_q == LENGTH_BITS'(OFS_ETYPE_LO)) begin
			hdr_nxt.etype[7:0] = data_byte;
		end else if (pos_q == LENGTH_BITS'(OFS_VIHL)) begin
			hdr_nxt.vihl = data_byte;
		end else if (pos_q == LENGTH_BITS'(OFS_PROTO)) begin
			hdr_nxt.proto = data_byte;
		end else if (pos_q >= LENGTH_BITS'(OFS_SRC) && pos_q < LENGTH_BITS'(OFS_DST)) begin
			hdr_nxt.src = {hdr_q.src[23:0], data_byte};
		end else if (pos_q >= LENGTH_BITS'(OFS_DST) && pos_q < LENGTH_BITS'(OFS_IP_END)) begin
			hdr_nxt.dst = {hdr_q.dst[23:0], data_byte};
		end
		if (pos_q > LENGTH_BITS'(OFS_VIHL) && ihl >= IHL_MIN) begin
			if (pos_q >= tl && pos_q <= tl + LENGTH_BITS'(3)) begin
				hdr_nxt.ports = {hdr_q.ports[23:0], data_byte};
			end else if (pos_q == tl + LENGTH_BITS'(OFS_FLAGS)) begin
				hdr_nxt.flags = {data_byte[0], 8'h00};
			end else if (pos_q == tl + LENGTH_BITS'(OFS_FLAGS) + LENGTH_BITS'(1)) begin
				hdr_nxt.flags = (hdr_q.flags | {1'b0, data_byte}) & FLAG_MASK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
			pos_q <= '0;
		end else if (take) begin
			if (last) begin
				hdr_q <= '0;
				pos_q <= '0;
			end else begin
				hdr_q <= hdr_nxt;
				pos_q <= len_nxt;
			end
		end
	end

endmodule

/* rtl/core/phcs_classify.sv */
// ----------------------------------------------------------------------------
// phcs_classify
// frame class, summary fields and event flags from the captured header
// ----------------------------------------------------------------------------
module phcs_classify #(
	parameter int LENGTH_BITS = 16
) (
	input  phcs_pkg::frame_t       hdr,
	input  logic [LENGTH_BITS-1:0] len,
	output phcs_pkg::summ_t        summ
);
	import phcs_pkg::*;

	logic [3:0]             ihl;
	logic [LENGTH_BITS-1:0] tl;
	logic                   ip_bad;
	logic [8:0]             fl;

	assign ihl = hdr.vihl[3:0];
	assign tl  = LENGTH_BITS'(transport_start(ihl));
	assign fl  = hdr.flags & FLAG_MASK;
	assign ip_bad = len < LENGTH_BITS'(OFS_IP_END) || hdr.vihl[7:4] != IP_VERSION4
		|| ihl < IHL_MIN || len < tl;

	always_comb begin
		summ = '0;
		if (len < LENGTH_BITS'(OFS_VIHL)) begin
			summ.cls = CLS_SHORT;
			summ.events[EV_UNKNOWN] = 1'b1;
		end else if (hdr.etype == ETYPE_ARP) begin
			summ.cls = CLS_ARP;
			summ.events[EV_ARP] = 1'b1;
		end else if (hdr.etype == ETYPE_IPV6) begin
			summ.cls = CLS_IPV6;
			summ.events[EV_IPV6] = 1'b1;
		end else if (hdr.etype != ETYPE_IPV4) begin
			summ.cls = CLS_OTHER_ET;
			summ.events[EV_UNKNOWN] = 1'b1;
		end else begin
			summ.events[EV_IPV4] = 1'b1;
			if (ip_bad) begin
				summ.cls = CLS_IPV4_BAD;
			end else begin
				summ.src = hdr.src;
				summ.dst = hdr.dst;
				if (hdr.proto == PROTO_ICMP) begin
					summ.cls = CLS_ICMP;
					summ.events[EV_ICMP] = 1'b1;
				end else if (hdr.proto == PROTO_TCP) begin
					summ.cls = CLS_TCP;
					summ.events[EV_TCP] = 1'b1;
					if (len >= tl + LENGTH_BITS'(TCP_HDR_LEN)) begin
						summ.pv    = 1'b1;
						summ.sport = hdr.ports[31:16];
						summ.dport = hdr.ports[15:0];
						summ.flags = fl;
						summ.events[EV_SYN] = |(fl & FLAG_SYN);
						summ.events[EV_ACK] = |(fl & FLAG_ACK);
						summ.events[EV_FIN] = |(fl & FLAG_FIN);
						summ.events[EV_RST] = |(fl & FLAG_RST);
						summ.events[EV_PSH] = |(fl & FLAG_PSH);
						summ.events[EV_URG] = |(fl & FLAG_URG);
					end
				end else if (hdr.proto == PROTO_UDP) begin
					summ.cls = CLS_UDP;
					summ.events[EV_UDP] = 1'b1;
					if (len >= tl + LENGTH_BITS'(UDP_HDR_LEN)) begin
						summ.pv    = 1'b1;
						summ.sport = hdr.ports[31:16];
						summ.dport = hdr.ports[15:0];
					end
				end else begin
					summ.cls = CLS_OTHER_PR;
					summ.events[EV_UNKNOWN] = 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/core/phcs_stats.sv */
// ----------------------------------------------------------------------------
// phcs_stats
// packet, byte, length and event counters with one readout port
// ----------------------------------------------------------------------------
module phcs_stats #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic [LENGTH_BITS-1:0]        len,
	input  logic [31:0]                   orig_len,
	input  logic [phcs_pkg::EVENT_N-1:0]  events,
	input  logic [4:0]                    sel,
	output logic [63:0]                   value
);
	import phcs_pkg::*;

	logic [31:0]            pkt_q;
	logic [63:0]            cap_bytes_q;
	logic [63:0]            orig_bytes_q;
	logic [31:0]            smallest_q;
	logic [31:0]            largest_q;
	logic [31:0]            ev_q [EVENT_N];
	logic [31:0]            len32;
	logic [EVENT_IDX_W-1:0] ev_idx;

	assign len32  = 32'(len);
	assign ev_idx = EVENT_IDX_W'(sel - SEL_EVENT_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q        <= '0;
			cap_bytes_q  <= '0;
			orig_bytes_q <= '0;
			smallest_q   <= '1;
			largest_q    <= '0;
			for (int i = 0; i < EVENT_N; i++) begin
				ev_q[i] <= '0;
			end
		end else if (upd) begin
			pkt_q        <= pkt_q + 32'd1;
			cap_bytes_q  <= cap_bytes_q + 64'(len);
			orig_bytes_q <= orig_bytes_q + 64'(orig_len);
			if (len32 < smallest_q) begin
				smallest_q <= len32;
			end
			if (len32 > largest_q) begin
				largest_q <= len32;
			end
			for (int i = 0; i < EVENT_N; i++) begin
				if (events[i]) begin
					ev_q[i] <= ev_q[i] + 32'd1;
				end
			end
		end
	end

	always_comb begin
		case (sel)
			SEL_PACKETS:    value = 64'(pkt_q);
			SEL_CAP_BYTES:  value = cap_bytes_q;
			SEL_ORIG_BYTES: value = orig_bytes_q;
			SEL_SMALLEST:   value = 64'(smallest_q);
			SEL_LARGEST:    value = 64'(largest_q);
			default: begin
				if (sel >= SEL_EVENT_BASE && sel < SEL_EVENT_END) begin
					value = 64'(ev_q[ev_idx]);
				end else begin
					value = '0;
				end
			end
		endcase
	end

endmodule

/* rtl/core/packet_header_classifier_stats.sv */
// ----------------------------------------------------------------------------
// packet_header_classifier_stats
// ethernet/ipv4/tcp/udp header classifier with capture statistics
//
//  channel  | dir | tdata fields (low bit up)                      | tuser | tlast
//  s_*      | in  | data_byte, original_length, counter_select     | mode  | last_byte
//  m_*      | out | class, addresses, ports, flags, length, counter | kind  | -
//
// one word per cycle while no result word is held back: input register, single pass of logic, result register
// a data word without tlast updates the header capture and gives no result
// a tlast word or a readout word gives one result word
// reset clears the frame capture and all counters; smallest length reads ones
// s_tready drops only while a result word waits and m_tready is low
// ----------------------------------------------------------------------------
`include "packet_header_classifier_stats_macros.svh"

module packet_header_classifier_stats #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// data_byte[7:0], original_length[39:8], counter_select[44:40], zero pad
	input  logic [phcs_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode
	input  logic                            s_tuser,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// packet_class[3:0], source_address[35:4], destination_address[67:36],
	// source_port[83:68], destination_port[99:84], ports_valid[100],
	// tcp_flags[109:101], captured_length[125:110], counter_value[189:126], zero pad
	output logic [phcs_pkg::OUT_DATA_W-1:0] m_tdata,
	// result_kind
	output logic                            m_tuser
);
	import phcs_pkg::*;

	logic                   valid_s1;
	logic                   mode_s1;
	logic                   last_s1;
	logic [7:0]             byte_s1;
	logic [31:0]            orig_s1;
	logic [4:0]             sel_s1;

	logic                   need_out;
	logic                   out_free;
	logic                   go_s1;
	logic                   out_load;
	logic                   frame_end;

	frame_t                 hdr_nxt;
	logic [LENGTH_BITS-1:0] len_nxt;
	summ_t                  summ;
	logic [63:0]            cnt_value;
	logic [OUT_DATA_W-1:0]  res_data;

	logic                   out_valid_q;
	logic                   out_kind_q;
	logic [OUT_DATA_W-1:0]  out_data_q;

	assign need_out  = mode_s1 || last_s1;
	assign out_free  = !out_valid_q || m_tready;
	assign go_s1     = valid_s1 && (!need_out || out_free);
	assign out_load  = go_s1 && need_out;
	assign frame_end = go_s1 && !mode_s1 && last_s1;
	assign s_tready  = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			last_s1 <= s_tlast;
			byte_s1 <= s_tdata[7:0];
			orig_s1 <= s_tdata[39:8];
			sel_s1  <= s_tdata[44:40];
		end
	end

	phcs_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (go_s1 && !mode_s1),
		.last     (last_s1),
		.data_byte(byte_s1),
		.hdr_nxt  (hdr_nxt),
		.len_nxt  (len_nxt)
	);

	phcs_classify #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_classify (
		.hdr (hdr_nxt),
		.len (len_nxt),
		.summ(summ)
	);

	phcs_stats #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (frame_end),
		.len     (len_nxt),
		.orig_len(orig_s1),
		.events  (summ.events),
		.sel     (sel_s1),
		.value   (cnt_value)
	);

	always_comb begin
		if (mode_s1) begin
			res_data = {2'b00, cnt_value, 126'd0};
		end else begin
			res_data = {2'b00, 64'd0, CAP_LEN_W'(len_nxt), summ.flags, summ.pv,
				summ.dport, summ.sport, summ.dst, summ.src, summ.cls};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= mode_s1;
			out_data_q <= res_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = out_data_q;

	`PHCS_ASSERT_IMP(a_load_only_when_free, clk, arst_n, out_load, out_free)
	`PHCS_ASSERT_IMP(a_readout_clean, clk, arst_n, m_tvalid && m_tuser, m_tdata[125:0] == '0)
	`PHCS_ASSERT_IMP(a_summary_no_counter, clk, arst_n, m_tvalid && !m_tuser,
		m_tdata[191:126] == '0)
	`PHCS_ASSERT_IMP(a_ports_need_l4, clk, arst_n, m_tvalid && !m_tuser && m_tdata[100],
		m_tdata[3:0] == CLS_TCP || m_tdata[3:0] == CLS_UDP)
	`PHCS_ASSERT_NXT(a_frame_end_result, clk, arst_n, frame_end, m_tvalid && !m_tuser)

endmodule
